FILE: hw/rtl/ttif_pkg.sv
// ----------------------------------------------------------------------------
// ttif_pkg
// Shared types and constants for the text tree indent formatter: character
// codes, register indexes and the command that moves from front to back.
// ----------------------------------------------------------------------------
package ttif_pkg;

   localparam int CharW  = 8;
   localparam int LevelW = 4;
   localparam int ColW   = 11;
   localparam int WrapW  = 10;
   localparam int IndW   = 3;
   localparam int IcolW  = 6;   // level * width, at most 15 * 4
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 10;
   localparam int HeadN  = 3;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_INDENT_WIDTH = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_SPACES_ONLY  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_WRAP_SOFT    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_WRAP_HARD    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_HALT_BRACE   = 3'd4;

   // characters
   localparam logic [CharW-1:0] CH_TAB    = 8'h09;
   localparam logic [CharW-1:0] CH_NL     = 8'h0A;
   localparam logic [CharW-1:0] CH_VT     = 8'h0B;
   localparam logic [CharW-1:0] CH_FF     = 8'h0C;
   localparam logic [CharW-1:0] CH_CR     = 8'h0D;
   localparam logic [CharW-1:0] CH_SPACE  = 8'h20;
   localparam logic [CharW-1:0] CH_QUOTE  = 8'h22;
   localparam logic [CharW-1:0] CH_COMMA  = 8'h2C;
   localparam logic [CharW-1:0] CH_LBRACE = 8'h7B;
   localparam logic [CharW-1:0] CH_RBRACE = 8'h7D;
   localparam logic [CharW-1:0] CH_TILDE  = 8'h7E;

   localparam logic [IcolW-1:0] TAB_COLS  = 6'd8;
   localparam logic [IndW-1:0]  MAX_WIDTH = 3'd4;
   localparam logic [ColW-1:0]  COL_MAX   = 11'h7FF;

   // one queued expansion: head characters, an indent run, an optional tail
   typedef struct packed {
      logic [HeadN-1:0][CharW-1:0] head;
      logic [1:0]                  head_cnt;
      logic [IcolW-1:0]            cols;
      logic                        use_tabs;
      logic                        tail_vld;
      logic [CharW-1:0]            tail;
      logic                        err;
   } cmd_type;

endpackage

FILE: hw/rtl/ttif_front.sv
// ----------------------------------------------------------------------------
// ttif_front
// Accepts input bytes, tracks nesting and string state, holds the
// configuration registers and turns each byte into at most one expansion command.
// ----------------------------------------------------------------------------
module ttif_front #(
   parameter int MAX_LEVEL = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [ttif_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [ttif_pkg::CsrDataW-1:0]  csr_wdata,
   input  logic                           accept,
   input  logic [ttif_pkg::CharW-1:0]     byte_in,
   input  logic                           end_of_file,
   output logic                           cmd_vld,
   output ttif_pkg::cmd_type              cmd
);
   import ttif_pkg::*;

   logic [IndW-1:0]   indent_width_ff;
   logic              spaces_only_ff;
   logic [WrapW-1:0]  wrap_soft_ff;
   logic [WrapW-1:0]  wrap_hard_ff;
   logic              halt_brace_ff;

   logic [LevelW-1:0] level_ff, level_in;
   logic              need_space_ff, need_space_in;
   logic              last_space_ff, last_space_in;
   logic              in_string_ff, in_string_in;
   logic [ColW-1:0]   column_ff, column_in;
   logic              halted_ff, halted_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         indent_width_ff <= 3'd2;
         spaces_only_ff  <= 1'b0;
         wrap_soft_ff    <= 10'd120;
         wrap_hard_ff    <= 10'd200;
         halt_brace_ff   <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_INDENT_WIDTH: indent_width_ff <= csr_wdata[IndW-1:0];
            CSR_SPACES_ONLY:  spaces_only_ff  <= csr_wdata[0];
            CSR_WRAP_SOFT:    wrap_soft_ff    <= csr_wdata[WrapW-1:0];
            CSR_WRAP_HARD:    wrap_hard_ff    <= csr_wdata[WrapW-1:0];
            CSR_HALT_BRACE:   halt_brace_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // classify the byte and build its command
   always_comb begin
      logic [IndW-1:0]   w;
      logic [LevelW-1:0] lvl;
      logic              wrap_blank;
      logic [ColW-1:0]   col1;
      logic              blank_in;

      level_in      = level_ff;
      need_space_in = need_space_ff;
      last_space_in = last_space_ff;
      in_string_in  = in_string_ff;
      column_in     = column_ff;
      halted_in     = halted_ff;
      cmd_vld       = 1'b0;
      cmd           = '0;
      cmd.use_tabs  = !spaces_only_ff;
      w    = (indent_width_ff > MAX_WIDTH) ? MAX_WIDTH : indent_width_ff;
      lvl  = level_ff;
      wrap_blank = 1'b0;
      col1 = column_ff;
      blank_in = (byte_in == CH_SPACE) || (byte_in == CH_TAB) || (byte_in == CH_VT) ||
                 (byte_in == CH_FF) || (byte_in == CH_CR);

      if (halted_ff) begin
         cmd_vld = 1'b0;
      end else if (end_of_file) begin
         in_string_in = 1'b0;
      end else if (in_string_ff) begin
         cmd_vld = 1'b1;
         if (byte_in == CH_NL) begin
            cmd.head[0]  = CH_TILDE;
            cmd.head[1]  = CH_NL;
            cmd.head_cnt = 2'd2;
            column_in    = '0;
         end else if (byte_in == CH_QUOTE) begin
            cmd.head[0]   = CH_QUOTE;
            cmd.head_cnt  = 2'd1;
            in_string_in  = 1'b0;
            need_space_in = 1'b1;
            last_space_in = 1'b0;
         end else if (byte_in == CH_LBRACE || byte_in == CH_RBRACE) begin
            cmd.head[0]  = byte_in;
            cmd.head_cnt = 2'd1;
            cmd.err      = halt_brace_ff;
            halted_in    = halt_brace_ff;
         end else begin
            wrap_blank = blank_in && (column_ff > {1'b0, wrap_soft_ff});
            col1 = wrap_blank ? '0 : column_ff;
            if (wrap_blank) begin
               cmd.head[0] = CH_NL;
               cmd.head[1] = byte_in;
            end else begin
               cmd.head[0] = byte_in;
            end
            if (col1 > {1'b0, wrap_hard_ff}) begin
               if (wrap_blank) begin
                  cmd.head[2]  = CH_NL;
                  cmd.head_cnt = 2'd3;
               end else begin
                  cmd.head[1]  = CH_NL;
                  cmd.head_cnt = 2'd2;
               end
               column_in = '0;
            end else begin
               cmd.head_cnt = wrap_blank ? 2'd2 : 2'd1;
               column_in    = (col1 < COL_MAX) ? col1 + 1'b1 : col1;
            end
         end
      end else begin
         case (byte_in) inside
            CH_QUOTE: begin
               cmd_vld = 1'b1;
               if (need_space_ff) begin
                  cmd.head[0]  = CH_SPACE;
                  cmd.head[1]  = CH_QUOTE;
                  cmd.head_cnt = 2'd2;
               end else begin
                  cmd.head[0]  = CH_QUOTE;
                  cmd.head_cnt = 2'd1;
               end
               column_in    = '0;
               in_string_in = 1'b1;
            end
            CH_LBRACE: begin
               cmd_vld = 1'b1;
               lvl = (level_ff < LevelW'(MAX_LEVEL)) ? level_ff + 1'b1 : level_ff;
               if (!last_space_ff) begin
                  cmd.head[0]  = CH_SPACE;
                  cmd.head[1]  = CH_LBRACE;
                  cmd.head[2]  = CH_NL;
                  cmd.head_cnt = 2'd3;
               end else begin
                  cmd.head[0]  = CH_LBRACE;
                  cmd.head[1]  = CH_NL;
                  cmd.head_cnt = 2'd2;
               end
               cmd.cols      = IcolW'(lvl) * IcolW'(w);
               level_in      = lvl;
               need_space_in = 1'b0;
               last_space_in = 1'b1;
            end
            CH_RBRACE: begin
               cmd_vld = 1'b1;
               lvl = (level_ff > '0) ? level_ff - 1'b1 : level_ff;
               cmd.head[0]   = CH_NL;
               cmd.head_cnt  = 2'd1;
               cmd.cols      = IcolW'(lvl) * IcolW'(w);
               cmd.tail_vld  = 1'b1;
               cmd.tail      = CH_RBRACE;
               level_in      = lvl;
               need_space_in = 1'b1;
               last_space_in = 1'b0;
            end
            CH_COMMA: begin
               cmd_vld = 1'b1;
               cmd.head[0]   = CH_COMMA;
               cmd.head[1]   = CH_NL;
               cmd.head_cnt  = 2'd2;
               cmd.cols      = IcolW'(level_ff) * IcolW'(w);
               need_space_in = 1'b0;
               last_space_in = 1'b1;
            end
            CH_SPACE, CH_TAB, CH_NL, CH_FF: begin
               if (!last_space_ff) need_space_in = 1'b1;
            end
            default: begin
               cmd_vld = 1'b1;
               if (need_space_ff && !last_space_ff) begin
                  cmd.head[0]  = CH_SPACE;
                  cmd.head[1]  = byte_in;
                  cmd.head_cnt = 2'd2;
               end else begin
                  cmd.head[0]  = byte_in;
                  cmd.head_cnt = 2'd1;
               end
               need_space_in = 1'b0;
               last_space_in = 1'b0;
            end
         endcase
      end
   end

   // advance the formatter state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         need_space_ff <= 1'b0;
         last_space_ff <= 1'b0;
         in_string_ff  <= 1'b0;
         column_ff     <= '0;
         halted_ff     <= 1'b0;
      end else if (accept) begin
         level_ff      <= level_in;
         need_space_ff <= need_space_in;
         last_space_ff <= last_space_in;
         in_string_ff  <= in_string_in;
         column_ff     <= column_in;
         halted_ff     <= halted_in;
      end
   end

endmodule

FILE: hw/rtl/ttif_queue.sv
// ----------------------------------------------------------------------------
// ttif_queue
// Short FIFO of expansion commands between front and back.
// ----------------------------------------------------------------------------
module ttif_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ttif_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output ttif_pkg::cmd_type pop_cmd
);
   import ttif_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type          slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // wrap pointers and track fill
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed command
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_cmd;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("queue count past depth");
   assert property (@(posedge clock) disable iff (reset) !(push && full && !pop))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");

endmodule

FILE: hw/rtl/ttif_back.sv
// ----------------------------------------------------------------------------
// ttif_back
// Expands one command at a time into output characters: head characters,
// then the indent run in tabs and spaces, then the tail character.
// ----------------------------------------------------------------------------
module ttif_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  ttif_pkg::cmd_type           q_cmd,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [ttif_pkg::CharW-1:0]  rsp_char_out,
   output logic                        rsp_last_of_run,
   output logic                        rsp_error_flag
);
   import ttif_pkg::*;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_HEAD   = 2'd1;
   localparam logic [1:0] PH_INDENT = 2'd2;
   localparam logic [1:0] PH_TAIL   = 2'd3;

   logic [1:0]       phase_ff, phase_in;
   cmd_type          cmd_ff;
   logic [1:0]       idx_ff, idx_in;
   logic [IcolW-1:0] cols_ff, cols_in;
   logic             out_vld_ff, out_vld_in;
   logic [CharW-1:0] out_char_ff;
   logic             out_last_ff;
   logic             out_err_ff;
   logic             advance;
   logic [CharW-1:0] ch;
   logic             done;

   assign advance = (phase_ff != PH_IDLE) && (!out_vld_ff || !rsp_stall);
   assign q_pop   = (phase_ff == PH_IDLE) && !q_empty;

   // pick the next character and the step after it
   always_comb begin
      logic [IcolW-1:0] left;
      phase_in = phase_ff;
      idx_in   = idx_ff;
      cols_in  = cols_ff;
      ch       = cmd_ff.tail;
      done     = 1'b0;
      left     = cols_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (q_pop) begin
               phase_in = PH_HEAD;
               idx_in   = '0;
               cols_in  = q_cmd.cols;
            end
         end
         PH_HEAD: begin
            ch = cmd_ff.head[idx_ff];
            if (advance) begin
               if (idx_ff + 1'b1 < cmd_ff.head_cnt) begin
                  idx_in = idx_ff + 1'b1;
               end else if (cols_ff != '0) begin
                  phase_in = PH_INDENT;
               end else if (cmd_ff.tail_vld) begin
                  phase_in = PH_TAIL;
               end else begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end else if (idx_ff + 1'b1 >= cmd_ff.head_cnt && cols_ff == '0 &&
                         !cmd_ff.tail_vld) begin
               done = 1'b1;
            end
         end
         PH_INDENT: begin
            if (cmd_ff.use_tabs && cols_ff >= TAB_COLS) begin
               ch   = CH_TAB;
               left = cols_ff - TAB_COLS;
            end else begin
               ch   = CH_SPACE;
               left = cols_ff - 1'b1;
            end
            done = (left == '0) && !cmd_ff.tail_vld;
            if (advance) begin
               cols_in = left;
               if (left == '0) phase_in = cmd_ff.tail_vld ? PH_TAIL : PH_IDLE;
            end
         end
         PH_TAIL: begin
            ch   = cmd_ff.tail;
            done = 1'b1;
            if (advance) phase_in = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // hold the result until taken, load a new one on advance
   always_comb begin
      if (advance)        out_vld_in = 1'b1;
      else if (rsp_stall) out_vld_in = out_vld_ff;
      else                out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         out_vld_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cols_ff <= cols_in;
      if (q_pop) cmd_ff <= q_cmd;
      if (advance) begin
         out_char_ff <= ch;
         out_last_ff <= done;
         out_err_ff  <= cmd_ff.err;
      end
   end

   assign rsp_valid       = out_vld_ff;
   assign rsp_char_out    = out_char_ff;
   assign rsp_last_of_run = out_last_ff;
   assign rsp_error_flag  = out_err_ff;

   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == PH_INDENT) |-> (cols_ff != '0))
      else $error("indent phase with no columns left");
   assert property (@(posedge clock) disable iff (reset)
                    q_pop |=> (phase_ff == PH_HEAD))
      else $error("loaded command did not start at its head");
   assert property (@(posedge clock) disable iff (reset)
                    $rose(out_vld_ff) |-> $past(phase_ff != PH_IDLE))
      else $error("result produced with no command in work");

endmodule

FILE: hw/rtl/text_tree_indent_formatter.sv
// ----------------------------------------------------------------------------
// text_tree_indent_formatter
// Streaming pretty-printer for brace-nested text: classifies each input byte
// in the front, queues an expansion command and emits the formatted bytes
// from the back, one character per cycle while the output is not stalled.
// An accepted byte's command passes the queue and the back's command register
// before its first character is registered in the back's single output register.
// Throughput: one output character per cycle while the output is not stalled, set
// by that register, with a gap between runs as the back loads the next command.
// Input is accepted while the command queue has room.
// Reset: synchronous; clears level, string and halt state, queue and output,
// and restores the register defaults.
// ----------------------------------------------------------------------------
module text_tree_indent_formatter #(
   parameter int MAX_LEVEL   = 15,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [ttif_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [ttif_pkg::CsrDataW-1:0]  csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ttif_pkg::CharW-1:0]     req_byte_in,
   input  logic                           req_end_of_file,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [ttif_pkg::CharW-1:0]     rsp_char_out,
   output logic                           rsp_last_of_run,
   output logic                           rsp_error_flag
);
   import ttif_pkg::*;

   logic    accept;
   logic    cmd_vld;
   cmd_type cmd;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   cmd_type q_cmd;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   ttif_front #(.MAX_LEVEL(MAX_LEVEL)) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .byte_in      (req_byte_in),
      .end_of_file  (req_end_of_file),
      .cmd_vld      (cmd_vld),
      .cmd          (cmd)
   );

   ttif_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept && cmd_vld),
      .push_cmd (cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .pop_cmd  (q_cmd)
   );

   ttif_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_char_out    (rsp_char_out),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_error_flag  (rsp_error_flag)
   );

endmodule
